@@ rtl/core/armb_pkg.sv @@
`timescale 1ns / 1ps

package armb_pkg;

    // Sizes of the two stores.
    localparam int HISTORY_DEPTH = 10;
    localparam int BLOCK_ENTRIES = 10;

    // Field widths.
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 32;
    localparam int THR_W   = 18;

    localparam logic [COUNT_W-1:0] BASE_RESET = COUNT_W'(100);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // History ring: pointer and running sum.
    localparam int HIST_CLOG = $clog2(HISTORY_DEPTH);
    localparam int POS_W     = (HISTORY_DEPTH > 1) ? HIST_CLOG : 1;
    localparam int SUM_W     = COUNT_W + HIST_CLOG;

    // Divide the sum by HISTORY_DEPTH through a reciprocal multiply.
    localparam int DIV_SHIFT = SUM_W + HIST_CLOG;
    localparam longint DIV_MULT =
        ((longint'(1) << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;

    // Block list fill count and slot index.
    localparam int USED_W = $clog2(BLOCK_ENTRIES + 1);
    localparam int IDX_W  = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef struct packed {
        logic hit;
        logic full;
    } t_blk_status;

endpackage

@@ rtl/core/armb_history.sv @@
`timescale 1ns / 1ps

module armb_history
    import armb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [COUNT_W-1:0] i_count,
    output logic [COUNT_W-1:0] o_avg
);

    logic [COUNT_W-1:0] r_hist [HISTORY_DEPTH];
    logic [POS_W-1:0]   r_pos;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [POS_W-1:0]   n_pos;
    logic [PROD_W-1:0]  prod;

    // Swap the oldest count for the new one in the running sum.
    assign n_sum = r_sum - SUM_W'(r_hist[r_pos]) + SUM_W'(i_count);
    assign n_pos = (r_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : r_pos + POS_W'(1);

    assign prod  = PROD_W'(n_sum) * PROD_W'(DIV_MULT);
    assign o_avg = prod[DIV_SHIFT +: COUNT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_tick) begin
            r_pos         <= n_pos;
            r_sum         <= n_sum;
            r_hist[r_pos] <= i_count;
        end
    end

endmodule

@@ rtl/core/armb_blocklist.sv @@
`timescale 1ns / 1ps

module armb_blocklist
    import armb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_key,
    input  logic              i_wr_en,
    output t_blk_status       o_status
);

    logic [ADDR_W-1:0] r_addr [BLOCK_ENTRIES];
    logic [USED_W-1:0] r_used;
    logic [BLOCK_ENTRIES-1:0] match;

    // Compare against every filled slot at once.
    always_comb begin
        for (int i = 0; i < BLOCK_ENTRIES; i++) begin
            match[i] = (USED_W'(i) < r_used) && (r_addr[i] == i_key);
        end
    end

    assign o_status.hit  = |match;
    assign o_status.full = (r_used == USED_W'(BLOCK_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr_en) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_addr[r_used[IDX_W-1:0]] <= i_key;
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(BLOCK_ENTRIES))
        else $error("block list fill count past capacity");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_status.full && !o_status.hit)
        else $error("block list write while full or already listed");
    a_write_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_used == $past(r_used) + USED_W'(1))
        else $error("block list write did not advance fill count");
`endif

endmodule

@@ rtl/core/adaptive_rate_monitor_blocklist.sv @@
`timescale 1ns / 1ps

// Request-rate monitor with an adaptive threshold and an address block list.
// Input channel (i_valid / o_stall): each request is either a client request
// (i_operation = request, address on i_client_ip) or an interval tick.
// Output channel (o_valid / i_stall): exactly one result per request, in order:
// rejected flag, alert level, newly-blocked flag and twice the threshold.
// Configuration (i_cfg_valid / o_cfg_ready): writes base_threshold; ready is
// always high, and writes are expected only while no request is in flight.
// A request passes the input register, then the result register, on its way
// from acceptance to o_valid. Throughput: one request per cycle while results
// are taken; the whole update (block list compare, history ring, reciprocal
// divide by the ring depth, threshold compare) sits between the two registers.
// Reset (synchronous, active low) clears the count, the history ring, the
// block list fill count, the last client and the alert; base_threshold
// returns to 100. No clearing pass is needed.
// Stall: when i_stall holds a valid result, the result register holds, the
// input register holds one more request, and o_stall rises until it drains.
module adaptive_rate_monitor_blocklist
    import armb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [ADDR_W-1:0]  i_client_ip,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_rejected,
    output logic               o_alert,
    output logic               o_newly_blocked,
    output logic [THR_W-1:0]   o_threshold_doubled,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    // Input register
    logic               r_in_vld;
    t_op                r_op;
    logic [ADDR_W-1:0]  r_ip;

    // Block state
    logic [COUNT_W-1:0] r_base;
    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]  r_last_client;
    logic               r_last_vld;
    logic               r_alert;

    // Result register
    logic               r_out_vld;
    logic               r_rejected;
    logic               r_alert_out;
    logic               r_newly;
    logic [THR_W-1:0]   r_thr2;

    logic               advance;
    logic               take;
    logic               is_tick;
    logic [ADDR_W-1:0]  key;
    t_blk_status        blk;
    logic [COUNT_W-1:0] avg;
    logic [THR_W-1:0]   thr2;
    logic               over;
    logic               add_entry;
    logic               n_alert;

    // Result register frees up when empty or when its result is taken.
    assign advance = !r_out_vld || !i_stall;
    assign take    = r_in_vld && advance;
    assign o_stall = r_in_vld && !advance;

    assign o_cfg_ready = 1'b1;

    assign is_tick = (r_op == OP_TICK);

    // One compare bank serves both: the request address, or on a tick the
    // last client that may be added.
    assign key = is_tick ? r_last_client : r_ip;

    armb_blocklist u_blocklist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key),
        .i_wr_en  (add_entry),
        .o_status (blk)
    );

    armb_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (take && is_tick),
        .i_count (r_count),
        .o_avg   (avg)
    );

    // Doubled threshold: 2*base + average; doubled count compared against it.
    assign thr2 = {1'b0, r_base, 1'b0} + THR_W'(avg);
    assign over = ({1'b0, r_count, 1'b0} > thr2);

    // Add the last client on alert if there is one, the list has room and
    // it is not already listed.
    assign add_entry = take && is_tick && over && r_last_vld && !blk.full && !blk.hit;

    assign n_alert = is_tick ? over : r_alert;

    // Input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op <= t_op'(i_operation);
            r_ip <= i_client_ip;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data;
        end
    end

    // Counter, last client and alert level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_last_client <= '0;
            r_last_vld    <= 1'b0;
            r_alert       <= 1'b0;
        end else if (take) begin
            if (is_tick) begin
                r_count <= '0;
                r_alert <= over;
            end else if (!blk.hit) begin
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                r_last_client <= r_ip;
                r_last_vld    <= 1'b1;
            end
        end
    end

    // Result register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rejected  <= !is_tick && blk.hit;
            r_alert_out <= n_alert;
            r_newly     <= add_entry;
            r_thr2      <= is_tick ? thr2 : '0;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_rejected          = r_rejected;
    assign o_alert             = r_alert_out;
    assign o_newly_blocked     = r_newly;
    assign o_threshold_doubled = r_thr2;

`ifndef SYNTHESIS
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> !o_newly_blocked && (o_threshold_doubled == '0))
        else $error("rejected request carries tick results");
    a_block_needs_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_newly_blocked |-> o_alert)
        else $error("client blocked without alert");
    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && is_tick |=> r_count == '0)
        else $error("request count not cleared by tick");
    a_alert_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_alert_out == r_alert)
        else $error("reported alert differs from held level");
`endif

endmodule

@@ dv/adaptive_rate_monitor_blocklist_tb.sv @@
`timescale 1ns / 1ps

module adaptive_rate_monitor_blocklist_tb;
    import armb_pkg::*;

    // Request as the sender holds it, and the result the monitor waits for.
    typedef struct {
        t_op              op;
        logic [ADDR_W-1:0] ip;
    } t_traffic;

    typedef struct {
        logic             rejected;
        logic             alert;
        logic             newly_blocked;
        logic [THR_W-1:0] thr2;
    } t_verdict;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALT
    } t_stall_mode;

    // DUT ports; every input starts at a known value.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic [ADDR_W-1:0]  i_client_ip = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_rejected;
    logic               o_alert;
    logic               o_newly_blocked;
    logic [THR_W-1:0]   o_threshold_doubled;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    // Requests still to be offered, and verdicts still owed by the block.
    t_traffic traffic_q[$];
    t_verdict verdict_q[$];
    t_traffic on_wire;

    // Shadow state of the rate monitor.
    int               base_thr;
    int               req_count;
    int               hist[HISTORY_DEPTH];
    int               hist_pos;
    int               hist_sum;
    logic [ADDR_W-1:0] blk_list[BLOCK_ENTRIES];
    int               blk_used;
    logic [ADDR_W-1:0] last_ip;
    logic             last_ip_ok;
    logic             alert_lvl;

    logic [ADDR_W-1:0] ip_pool[16];

    int          err_count = 0;
    int          n_accepted = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic        next_stall;
    logic        hold_long = 1'b0;
    t_verdict    exp_v;

    adaptive_rate_monitor_blocklist uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_client_ip         (i_client_ip),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_rejected          (o_rejected),
        .o_alert             (o_alert),
        .o_newly_blocked     (o_newly_blocked),
        .o_threshold_doubled (o_threshold_doubled),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Scan only the filled part of the block list.
    function automatic logic is_listed(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < blk_used; i++) begin
            if (blk_list[i] == addr) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the shadow monitor by one request and return its verdict.
    function automatic t_verdict next_verdict(t_traffic t);
        t_verdict v;
        int       avg;
        int       thr2;
        v = '{default: '0};
        if (t.op == OP_REQUEST) begin
            if (is_listed(t.ip)) begin
                v.rejected = 1'b1;
            end else begin
                if (req_count < int'(COUNT_MAX)) req_count++;
                last_ip = t.ip;
                last_ip_ok = 1'b1;
            end
        end else begin
            // Retire the oldest interval from the ring and push the new one.
            hist_sum = hist_sum - hist[hist_pos] + req_count;
            hist[hist_pos] = req_count;
            hist_pos = (hist_pos + 1) % HISTORY_DEPTH;
            avg = hist_sum / HISTORY_DEPTH;
            thr2 = 2 * base_thr + avg;
            if (2 * req_count > thr2) begin
                alert_lvl = 1'b1;
                // Block the last client only once, and only while room is left.
                if (last_ip_ok && blk_used < BLOCK_ENTRIES && !is_listed(last_ip)) begin
                    blk_list[blk_used] = last_ip;
                    blk_used++;
                    v.newly_blocked = 1'b1;
                end
            end else begin
                alert_lvl = 1'b0;
            end
            req_count = 0;
            v.thr2 = THR_W'(thr2);
        end
        v.alert = alert_lvl;
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_ip();
        if ($urandom_range(0, 7) < 3) return ip_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    task automatic push_item(input t_op op, input logic [ADDR_W-1:0] ip);
        t_traffic t;
        t.op = op;
        t.ip = ip;
        traffic_q.push_back(t);
    endtask

    // One interval: n requests followed by the tick that closes it.
    task automatic queue_interval(input int n);
        for (int k = 0; k < n; k++) push_item(OP_REQUEST, pick_ip());
        push_item(OP_TICK, $urandom);
    endtask

    // Mostly well-formed intervals sized around the threshold, plus stray items.
    task automatic queue_traffic(input int n_items);
        int added;
        int n;
        int cap;
        added = 0;
        cap = (base_thr > 16) ? 40 : 2 * base_thr + 8;
        while (added < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_item(OP_TICK, $urandom);
                    added += 1;
                end
                1: begin
                    push_item(OP_REQUEST, pick_ip());
                    added += 1;
                end
                default: begin
                    n = $urandom_range(0, cap);
                    queue_interval(n);
                    added += n + 1;
                end
            endcase
        end
    endtask

    // Wait until every queued request is taken and every verdict is back;
    // look between edges so the sender's updates have landed.
    task automatic settle();
        @(negedge i_clk);
        while (traffic_q.size() != 0 || i_valid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write base_threshold; call only while the block is idle.
    task automatic write_base(input logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_thr = int'(value);
    endtask

    // Sender: offer requests in bursts with random gaps; hold while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                verdict_q.push_back(next_verdict(on_wire));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (traffic_q.size() != 0) begin
                    on_wire = traffic_q.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= on_wire.op;
                    i_client_ip <= on_wire.ip;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // Now and then run a long burst with no gap at all.
                        burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
                        gap_left = $urandom_range(0, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each verdict taken, then pick the next stall value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_rejected !== exp_v.rejected) begin
                        $error("rejected: expected %0d, actual %0d", exp_v.rejected, o_rejected);
                        err_count++;
                    end
                    if (o_alert !== exp_v.alert) begin
                        $error("alert: expected %0d, actual %0d", exp_v.alert, o_alert);
                        err_count++;
                    end
                    if (o_newly_blocked !== exp_v.newly_blocked) begin
                        $error("newly_blocked: expected %0d, actual %0d",
                               exp_v.newly_blocked, o_newly_blocked);
                        err_count++;
                    end
                    if (o_threshold_doubled !== exp_v.thr2) begin
                        $error("threshold_doubled: expected %0d, actual %0d",
                               exp_v.thr2, o_threshold_doubled);
                        err_count++;
                    end
                end
            end
            // Switch to a new random stall pattern when the current one runs out.
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 120);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                STALL_NONE:  next_stall = 1'b0;
                STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
                default:     next_stall = ~i_stall;
            endcase
            i_stall <= hold_long | next_stall;
        end
    end

    // Hold off the receiver for a long stretch while traffic keeps coming,
    // so the block fills and pushes back on its input.
    initial begin
        wait (n_accepted >= 200);
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    // Hard limit on the run.
    initial begin
        #20_000_000;
        $display("adaptive_rate_monitor_blocklist_tb: FAIL");
        $finish;
    end

    initial begin
        base_thr = int'(BASE_RESET);
        req_count = 0;
        hist_pos = 0;
        hist_sum = 0;
        blk_used = 0;
        last_ip = '0;
        last_ip_ok = 1'b0;
        alert_lvl = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = 0;
        for (int i = 0; i < BLOCK_ENTRIES; i++) blk_list[i] = '0;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        ip_pool[2] = 32'h0A00_0001;
        ip_pool[3] = 32'hC0A8_0101;
        for (int i = 4; i < 16; i++) ip_pool[i] = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Base at its reset value: two requests stay well below threshold.
        push_item(OP_REQUEST, 32'h0000_0000);
        push_item(OP_REQUEST, 32'hFFFF_FFFF);
        push_item(OP_TICK, 32'h0000_0000);
        push_item(OP_TICK, 32'hFFFF_FFFF);
        settle();

        // Zero base: a single request raises the alert and blocks its client.
        write_base('0);
        push_item(OP_REQUEST, 32'h0A00_0001);
        push_item(OP_TICK, '0);
        push_item(OP_REQUEST, 32'h0A00_0001);   // listed now, drop it
        push_item(OP_REQUEST, 32'h0000_0000);
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '0);                 // empty interval clears alert
        push_item(OP_REQUEST, 32'h0A00_0001);
        push_item(OP_REQUEST, 32'hFFFF_FFFF);
        push_item(OP_REQUEST, 32'hC0A8_0101);
        push_item(OP_TICK, '1);
        settle();

        // Random traffic across several thresholds; the list fills up here.
        write_base(COUNT_W'($urandom_range(2, 12)));
        queue_traffic(600);
        settle();

        write_base('0);
        queue_traffic(400);
        settle();

        write_base('1);
        queue_traffic(200);
        settle();

        // One long interval pushes the count far above the threshold.
        write_base('0);
        queue_interval(150);
        queue_interval(3);
        settle();

        write_base(COUNT_W'($urandom_range(1, 15)));
        queue_traffic(400);
        settle();

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("adaptive_rate_monitor_blocklist_tb: PASS");
        end else begin
            $display("adaptive_rate_monitor_blocklist_tb: FAIL");
        end
        $finish;
    end

endmodule
